FILE: sv/cdq_pkg.sv
`default_nettype none

package cdq_pkg;

   // Field widths fixed by the stream format
   localparam int REQ_DATA_W = 32;
   localparam int FUNC_W     = 3;
   localparam int RSP_WORD_W = 32;
   localparam int STATUS_W   = 2;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_ADD_BACK   = 3'd0,
      FUNC_ADD_FRONT  = 3'd1,
      FUNC_TAKE_BACK  = 3'd2,
      FUNC_TAKE_FRONT = 3'd3,
      FUNC_NONE       = 3'd4
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_OK    = 2'd0,
      STATUS_FULL  = 2'd1,
      STATUS_EMPTY = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_EXEC = 4'b0010,
      ST_FILL = 4'b0100,
      ST_DONE = 4'b1000
   } state_type;

endpackage

`default_nettype wire

FILE: sv/cdq_ram.sv
`default_nettype none

module cdq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             en,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // single port, registered read
   always_ff @(posedge clock) begin
      if (en) begin
         if (we) begin
            mem_ff[addr] <= wdata;
         end else begin
            rdata <= mem_ff[addr];
         end
      end
   end

endmodule

`default_nettype wire

FILE: sv/circular_deque.sv
`default_nettype none

// Double-ended queue of DEPTH words kept in a single-port ring buffer RAM.
// Each request word carries an operation in req_tuser (push back, push front,
// pop back, pop front, none; unused codes act as none) and the word to push in
// req_tdata. Every request gives exactly one response word: status (ok, full,
// empty), the popped word, the front and back words after the step, the count
// and empty/full flags. A refused push or pop leaves the queue untouched.
// The front and back words are cached in registers beside the RAM, so only a
// pop that leaves words behind has to read the RAM to refill the cached end.
// One request is in flight at a time: a step goes from acceptance through the
// EXEC and DONE states to the response register, with a FILL state between them
// for a pop that leaves the queue non-empty (it waits for the registered RAM
// read); a response stalled by rsp_tready holds the step in DONE. A new request
// is taken while the previous response still waits. RAM contents need no
// initialisation: only stored entries are ever read.
module circular_deque #(
   parameter int  DEPTH      = 16,
   parameter int  WORD_WIDTH = 32,
   localparam int AW         = (DEPTH > 1) ? $clog2(DEPTH) : 1,
   localparam int CNT_W      = $clog2(DEPTH + 1),
   localparam int RSP_BITS   = cdq_pkg::STATUS_W + 3 * cdq_pkg::RSP_WORD_W + CNT_W + 2,
   localparam int RSP_W      = 8 * ((RSP_BITS + 7) / 8)
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_tvalid,
   output logic                                 req_tready,
   // data_in
   input  wire logic [cdq_pkg::REQ_DATA_W-1:0]  req_tdata,
   // func
   input  wire logic [cdq_pkg::FUNC_W-1:0]      req_tuser,
   output logic                                 rsp_tvalid,
   input  wire logic                            rsp_tready,
   // status, popped_value, front_value, back_value, item_count,
   // is_empty, is_full, zero padding
   output logic [RSP_W-1:0]                     rsp_tdata
);

   localparam int RW = cdq_pkg::RSP_WORD_W;

   cdq_pkg::state_type state_ff, state_in;

   logic [cdq_pkg::FUNC_W-1:0]   func_ff;
   logic [cdq_pkg::REQ_DATA_W-1:0] data_ff;
   logic [AW-1:0]                head_ff, head_in;
   logic [AW-1:0]                tail_ff, tail_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [WORD_WIDTH-1:0]        front_ff, front_in;  // cached word at head
   logic [WORD_WIDTH-1:0]        back_ff, back_in;    // cached word at tail
   logic [WORD_WIDTH-1:0]        popped_ff, popped_in;
   logic [cdq_pkg::STATUS_W-1:0] status_ff, status_in;
   logic                         fill_back_ff, fill_back_in;
   logic                         rsp_valid_ff;
   logic [RSP_W-1:0]             rsp_data_ff;

   logic                  ram_en, ram_we;
   logic [AW-1:0]         ram_addr;
   logic [WORD_WIDTH-1:0] ram_rdata;
   logic [WORD_WIDTH-1:0] push_word;
   logic                  is_empty, is_full;
   logic                  rsp_free;
   logic [AW-1:0]         tail_inc, tail_dec, head_inc, head_dec;

   // word widths between stream and storage: zero-extend then truncate
   logic [WORD_WIDTH+cdq_pkg::REQ_DATA_W-1:0] push_ext;
   logic [RW+WORD_WIDTH-1:0] pop_ext, front_ext, back_ext;

   assign push_ext  = {{WORD_WIDTH{1'b0}}, data_ff};
   assign push_word = push_ext[WORD_WIDTH-1:0];
   assign pop_ext   = {{RW{1'b0}}, popped_ff};
   assign front_ext = {{RW{1'b0}}, front_ff};
   assign back_ext  = {{RW{1'b0}}, back_ff};

   assign is_empty = (count_ff == '0);
   assign is_full  = (count_ff == CNT_W'(DEPTH));

   // ring index steps
   assign tail_inc = (tail_ff == AW'(DEPTH - 1)) ? '0 : tail_ff + 1'b1;
   assign tail_dec = (tail_ff == '0) ? AW'(DEPTH - 1) : tail_ff - 1'b1;
   assign head_inc = (head_ff == AW'(DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? AW'(DEPTH - 1) : head_ff - 1'b1;

   assign rsp_free   = !rsp_valid_ff || rsp_tready;
   assign req_tready = (state_ff == cdq_pkg::ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      count_in     = count_ff;
      front_in     = front_ff;
      back_in      = back_ff;
      popped_in    = popped_ff;
      status_in    = status_ff;
      fill_back_in = fill_back_ff;
      ram_en       = 1'b0;
      ram_we       = 1'b0;
      ram_addr     = head_ff;

      case (state_ff)
         cdq_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               state_in = cdq_pkg::ST_EXEC;
            end
         end
         cdq_pkg::ST_EXEC: begin
            popped_in = '0;
            status_in = cdq_pkg::STATUS_OK;
            state_in  = cdq_pkg::ST_DONE;
            case (func_ff)
               cdq_pkg::FUNC_ADD_BACK, cdq_pkg::FUNC_ADD_FRONT: begin
                  if (is_full) begin
                     status_in = cdq_pkg::STATUS_FULL;
                  end else begin
                     count_in = count_ff + 1'b1;
                     ram_en   = 1'b1;
                     ram_we   = 1'b1;
                     if (is_empty) begin
                        // first word always lands in slot 0
                        head_in  = '0;
                        tail_in  = '0;
                        ram_addr = '0;
                        front_in = push_word;
                        back_in  = push_word;
                     end else if (func_ff == cdq_pkg::FUNC_ADD_BACK) begin
                        tail_in  = tail_inc;
                        ram_addr = tail_inc;
                        back_in  = push_word;
                     end else begin
                        head_in  = head_dec;
                        ram_addr = head_dec;
                        front_in = push_word;
                     end
                  end
               end
               cdq_pkg::FUNC_TAKE_BACK: begin
                  if (is_empty) begin
                     status_in = cdq_pkg::STATUS_EMPTY;
                  end else begin
                     popped_in = back_ff;
                     count_in  = count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        // refill cached back word from the new tail
                        tail_in      = tail_dec;
                        ram_addr     = tail_dec;
                        ram_en       = 1'b1;
                        fill_back_in = 1'b1;
                        state_in     = cdq_pkg::ST_FILL;
                     end
                  end
               end
               cdq_pkg::FUNC_TAKE_FRONT: begin
                  if (is_empty) begin
                     status_in = cdq_pkg::STATUS_EMPTY;
                  end else begin
                     popped_in = front_ff;
                     count_in  = count_ff - 1'b1;
                     if (count_ff == CNT_W'(1)) begin
                        head_in = '0;
                        tail_in = '0;
                     end else begin
                        head_in      = head_inc;
                        ram_addr     = head_inc;
                        ram_en       = 1'b1;
                        fill_back_in = 1'b0;
                        state_in     = cdq_pkg::ST_FILL;
                     end
                  end
               end
               cdq_pkg::FUNC_NONE: begin
               end
               default: begin
                  // unused codes leave everything as is
               end
            endcase
         end
         cdq_pkg::ST_FILL: begin
            if (fill_back_ff) begin
               back_in = ram_rdata;
            end else begin
               front_in = ram_rdata;
            end
            state_in = cdq_pkg::ST_DONE;
         end
         cdq_pkg::ST_DONE: begin
            if (rsp_free) begin
               state_in = cdq_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = cdq_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= cdq_pkg::ST_IDLE;
         head_ff      <= '0;
         tail_ff      <= '0;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
         if (state_ff == cdq_pkg::ST_DONE && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         func_ff <= req_tuser;
         data_ff <= req_tdata;
      end
      front_ff     <= front_in;
      back_ff      <= back_in;
      popped_ff    <= popped_in;
      status_ff    <= status_in;
      fill_back_ff <= fill_back_in;
      if (state_ff == cdq_pkg::ST_DONE && rsp_free) begin
         rsp_data_ff <= RSP_W'({is_full,
                                is_empty,
                                count_ff,
                                is_empty ? {RW{1'b0}} : back_ext[RW-1:0],
                                is_empty ? {RW{1'b0}} : front_ext[RW-1:0],
                                pop_ext[RW-1:0],
                                status_ff});
      end
   end

   cdq_ram #(
      .WIDTH (WORD_WIDTH),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock (clock),
      .en    (ram_en),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (push_word),
      .rdata (ram_rdata)
   );

endmodule

`default_nettype wire

FILE: verif/tb.sv
`timescale 1ns / 100ps

module tb;

   localparam int DEPTH          = 16;
   localparam int CNT_W          = 5;
   localparam int STATUS_W       = cdq_pkg::STATUS_W;
   localparam int RSP_WORD_W     = cdq_pkg::RSP_WORD_W;
   localparam int REQ_DATA_W     = cdq_pkg::REQ_DATA_W;
   localparam int FUNC_W         = cdq_pkg::FUNC_W;
   localparam int RSP_BITS       = STATUS_W + 3 * RSP_WORD_W + CNT_W + 2;
   localparam int RSP_W          = 8 * ((RSP_BITS + 7) / 8);
   // response word layout, lowest bit up
   localparam int POP_LSB        = STATUS_W;
   localparam int FRONT_LSB      = POP_LSB + RSP_WORD_W;
   localparam int BACK_LSB       = FRONT_LSB + RSP_WORD_W;
   localparam int CNT_LSB        = BACK_LSB + RSP_WORD_W;
   localparam int EMPTY_BIT      = CNT_LSB + CNT_W;
   localparam int FULL_BIT       = EMPTY_BIT + 1;

   // op codes outside the enum, all treated as no-op
   localparam logic [FUNC_W-1:0] FUNC_SPARE_LO  = 3'd5;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_MID = 3'd6;
   localparam logic [FUNC_W-1:0] FUNC_SPARE_HI  = 3'd7;

   localparam int LEAN_FILL      = 0;
   localparam int LEAN_DRAIN     = 1;
   localparam int LEAN_MIX       = 2;

   localparam int N_RANDOM       = 1420;
   localparam int HOLD_CYCLES    = 300;
   localparam int HOLD_AFTER     = 700;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int TAIL_CYCLES    = 16;

   typedef struct packed {
      cdq_pkg::status_type     status;
      logic [RSP_WORD_W-1:0]   popped;
      logic [RSP_WORD_W-1:0]   front;
      logic [RSP_WORD_W-1:0]   back;
      logic [CNT_W-1:0]        count;
      logic                    empty;
      logic                    full;
   } rsp_type;

   typedef struct packed {
      logic [FUNC_W-1:0]       op;
      logic [REQ_DATA_W-1:0]   word;
      logic [4:0]              reps;    // data increments per repeat
      logic                    fixed;   // want is typed in, else predicted
      rsp_type                 want;
   } dir_row_type;

   localparam int DIR_ROWS = 16;
   localparam dir_row_type DIR_TAB [DIR_ROWS] = '{
      // empty after reset: pops refused, no-ops harmless
      '{cdq_pkg::FUNC_TAKE_BACK,  32'h0000_0000, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      '{cdq_pkg::FUNC_TAKE_FRONT, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_EMPTY, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      '{cdq_pkg::FUNC_NONE,       32'h1234_5678, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      '{FUNC_SPARE_HI,            32'hFFFF_FFFF, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      // data extremes at both ends
      '{cdq_pkg::FUNC_ADD_BACK,   32'hFFFF_FFFF, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 5'd1, 1'b0, 1'b0}},
      '{cdq_pkg::FUNC_ADD_FRONT,  32'h0000_0000, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0}},
      '{FUNC_SPARE_MID,           32'h0000_0000, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'h0, 32'hFFFF_FFFF, 5'd2, 1'b0, 1'b0}},
      '{cdq_pkg::FUNC_TAKE_BACK,  32'h0000_0000, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'hFFFF_FFFF, 32'h0, 32'h0, 5'd1, 1'b0, 1'b0}},
      // last word out, indices go home
      '{cdq_pkg::FUNC_TAKE_FRONT, 32'hFFFF_FFFF, 5'd1, 1'b1,
        '{cdq_pkg::STATUS_OK, 32'h0, 32'h0, 32'h0, 5'd0, 1'b1, 1'b0}},
      // fill from both ends, front push into empty first
      '{cdq_pkg::FUNC_ADD_FRONT,  32'hA5A5_0000, 5'd8, 1'b0, '0},
      '{cdq_pkg::FUNC_ADD_BACK,   32'h5A5A_0000, 5'd8, 1'b0, '0},
      // pushes refused while full, then a no-op and a pop from each end
      '{cdq_pkg::FUNC_ADD_BACK,   32'hDEAD_BEEF, 5'd1, 1'b0, '0},
      '{cdq_pkg::FUNC_ADD_FRONT,  32'h0000_0001, 5'd1, 1'b0, '0},
      '{FUNC_SPARE_LO,            32'h0000_0000, 5'd1, 1'b0, '0},
      '{cdq_pkg::FUNC_TAKE_FRONT, 32'h0000_0000, 5'd1, 1'b0, '0},
      '{cdq_pkg::FUNC_TAKE_BACK,  32'h0000_0000, 5'd1, 1'b0, '0}
   };

   logic                     clock      = 1'b0;
   logic                     reset      = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_W-1:0]    req_tdata  = '0;     // data_in
   logic [FUNC_W-1:0]        req_tuser  = cdq_pkg::FUNC_NONE;  // func
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b0;
   // status, popped_value, front_value, back_value, item_count,
   // is_empty, is_full, zero padding
   logic [RSP_W-1:0]         rsp_tdata;

   logic [FUNC_W-1:0]        stim_op    [$];
   logic [REQ_DATA_W-1:0]    stim_word  [$];
   logic                     stim_fixed [$];
   rsp_type                  stim_want  [$];

   logic [RSP_WORD_W-1:0]    shadow_words [$];   // front at index 0
   rsp_type                  owed_rsp     [$];

   int                       n_taken    = 0;
   int                       n_err      = 0;
   int                       stall_cycles = 0;
   bit                       all_sent   = 1'b0;

   always #4 clock = ~clock;

   circular_deque u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // applies one op to the shadow deque and returns the response it owes
   function automatic rsp_type step_deque(logic [FUNC_W-1:0] op,
                                          logic [REQ_DATA_W-1:0] word);
      rsp_type r;
      r = '0;
      r.status = cdq_pkg::STATUS_OK;
      case (op)
         cdq_pkg::FUNC_ADD_BACK, cdq_pkg::FUNC_ADD_FRONT: begin
            if (shadow_words.size() >= DEPTH)
               r.status = cdq_pkg::STATUS_FULL;
            else if (op == cdq_pkg::FUNC_ADD_BACK)
               shadow_words.insert(shadow_words.size(), word);
            else
               shadow_words.insert(0, word);
         end
         cdq_pkg::FUNC_TAKE_BACK, cdq_pkg::FUNC_TAKE_FRONT: begin
            if (shadow_words.size() == 0) begin
               r.status = cdq_pkg::STATUS_EMPTY;
            end else if (op == cdq_pkg::FUNC_TAKE_BACK) begin
               r.popped = shadow_words[shadow_words.size() - 1];
               shadow_words.delete(shadow_words.size() - 1);
            end else begin
               r.popped = shadow_words[0];
               shadow_words.delete(0);
            end
         end
         default: ;
      endcase
      if (shadow_words.size() != 0) begin
         r.front = shadow_words[0];
         r.back  = shadow_words[shadow_words.size() - 1];
      end
      r.count = CNT_W'(shadow_words.size());
      r.empty = (shadow_words.size() == 0);
      r.full  = (shadow_words.size() >= DEPTH);
      return r;
   endfunction

   function automatic rsp_type unpack_rsp(logic [RSP_W-1:0] w);
      rsp_type r;
      r.status = cdq_pkg::status_type'(w[STATUS_W-1:0]);
      r.popped = w[POP_LSB +: RSP_WORD_W];
      r.front  = w[FRONT_LSB +: RSP_WORD_W];
      r.back   = w[BACK_LSB +: RSP_WORD_W];
      r.count  = w[CNT_LSB +: CNT_W];
      r.empty  = w[EMPTY_BIT];
      r.full   = w[FULL_BIT];
      return r;
   endfunction

   task automatic check_field(string what, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         n_err++;
         $display("%0t: %s expected %h, got %h", $time, what, want, got);
      end
   endtask

   // scoreboard: predict on request handshake, compare on response handshake
   always @(posedge clock) begin
      rsp_type pred;
      rsp_type want;
      rsp_type got;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            pred = step_deque(req_tuser, req_tdata);
            owed_rsp.insert(owed_rsp.size(),
                            stim_fixed[n_taken] ? stim_want[n_taken] : pred);
            n_taken++;
         end
         if (rsp_tvalid && rsp_tready) begin
            got = unpack_rsp(rsp_tdata);
            if (owed_rsp.size() == 0) begin
               n_err++;
               $display("%0t: response word with none expected, got %h", $time, rsp_tdata);
            end else begin
               want = owed_rsp[0];
               owed_rsp.delete(0);
               check_field("status",       32'(want.status), 32'(got.status));
               check_field("popped_value", want.popped,      got.popped);
               check_field("front_value",  want.front,       got.front);
               check_field("back_value",   want.back,        got.back);
               check_field("item_count",   32'(want.count),  32'(got.count));
               check_field("is_empty",     32'(want.empty),  32'(got.empty));
               check_field("is_full",      32'(want.full),   32'(got.full));
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // sender
   initial begin
      int  gap;
      bit  calm;
      wait (!reset);
      @(posedge clock);
      for (int i = 0; i < stim_op.size(); i++) begin
         if (i % 50 == 0)
            calm = ($urandom_range(0, 3) == 0);
         gap = calm ? 0 : $urandom_range(0, 15);
         if (gap != 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         req_tvalid <= 1'b1;
         req_tdata  <= stim_word[i];
         req_tuser  <= stim_op[i];
         @(posedge clock);
         while (!req_tready) @(posedge clock);
      end
      req_tvalid <= 1'b0;
      all_sent = 1'b1;
   end

   // receiver; one long hold-off midway lets the block back up into the input
   initial begin
      int  gap;
      int  n_seen;
      bit  calm;
      bit  held;
      n_seen = 0;
      held   = 1'b0;
      wait (!reset);
      @(posedge clock);
      forever begin
         if (n_seen % 50 == 0)
            calm = ($urandom_range(0, 3) == 0);
         if (!held && n_taken >= HOLD_AFTER) begin
            held = 1'b1;
            gap  = HOLD_CYCLES;
         end else begin
            gap  = calm ? 0 : $urandom_range(0, 15);
         end
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         n_seen++;
      end
   end

   initial begin
      int                     lean;
      int                     pick;
      bit                     push;
      logic [FUNC_W-1:0]      op;
      logic [REQ_DATA_W-1:0]  word;

      for (int r = 0; r < DIR_ROWS; r++) begin
         for (int k = 0; k < DIR_TAB[r].reps; k++) begin
            stim_op.insert(stim_op.size(), DIR_TAB[r].op);
            stim_word.insert(stim_word.size(), REQ_DATA_W'(DIR_TAB[r].word + k));
            stim_fixed.insert(stim_fixed.size(), DIR_TAB[r].fixed);
            stim_want.insert(stim_want.size(), DIR_TAB[r].want);
         end
      end

      // random phases lean towards filling, draining or neither
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i % 40 == 0)
            lean = $urandom_range(LEAN_FILL, LEAN_MIX);
         pick = $urandom_range(0, 99);
         if (pick < 2) begin
            op = cdq_pkg::FUNC_NONE;
         end else if (pick < 5) begin
            op = FUNC_W'($urandom_range(FUNC_SPARE_LO, FUNC_SPARE_HI));
         end else begin
            pick = $urandom_range(0, 99);
            case (lean)
               LEAN_FILL:  push = (pick < 75);
               LEAN_DRAIN: push = (pick < 25);
               default:    push = (pick < 50);
            endcase
            if (push)
               op = $urandom_range(0, 1) ? cdq_pkg::FUNC_ADD_FRONT
                                         : cdq_pkg::FUNC_ADD_BACK;
            else
               op = $urandom_range(0, 1) ? cdq_pkg::FUNC_TAKE_FRONT
                                         : cdq_pkg::FUNC_TAKE_BACK;
         end
         if ($urandom_range(0, 7) == 0)
            word = $urandom_range(0, 1) ? '1 : '0;
         else
            word = $urandom;
         stim_op.insert(stim_op.size(), op);
         stim_word.insert(stim_word.size(), word);
         stim_fixed.insert(stim_fixed.size(), 1'b0);
         stim_want.insert(stim_want.size(), rsp_type'('0));
      end

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      wait (all_sent);
      while (owed_rsp.size() != 0 || n_taken < stim_op.size()) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);

      if (owed_rsp.size() != 0) begin
         n_err++;
         $display("%0t: %0d response words never arrived", $time, owed_rsp.size());
      end
      if (n_err == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
